// ===== src/y2argb_pkg.sv =====
// ---------------------------------------------------------------------------
// y2argb_pkg
// Shared types and constants of the YUV 4:2:2 pair to ARGB converter.
// ---------------------------------------------------------------------------
package y2argb_pkg;

    localparam int LUMA_W  = 8;
    localparam int PIXEL_W = 32;
    localparam int PROD_W  = 17;
    localparam int DELTA_W = 9;
    localparam int SUM_W   = 10;

    localparam logic signed [PROD_W-1:0] COEF_RV = 17'sd351;
    localparam logic signed [PROD_W-1:0] COEF_GV = 17'sd179;
    localparam logic signed [PROD_W-1:0] COEF_GU = 17'sd86;
    localparam logic signed [PROD_W-1:0] COEF_BU = 17'sd443;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] CHAN_MAX     = 8'hFF;

    // chroma contributions shared by both pixels of a pair
    typedef struct packed {
        logic signed [DELTA_W-1:0] dr;
        logic signed [DELTA_W-1:0] dg;
        logic signed [DELTA_W-1:0] db;
    } delta_t;

endpackage

// ===== src/y2argb_chroma.sv =====
// ---------------------------------------------------------------------------
// y2argb_chroma
// Centers Cb/Cr and forms the floored red, green and blue chroma terms.
// ---------------------------------------------------------------------------
module y2argb_chroma (
    input  logic [7:0]        chroma_blue,
    input  logic [7:0]        chroma_red,
    output y2argb_pkg::delta_t delta
);
    import y2argb_pkg::*;

    logic signed [7:0]        u;
    logic signed [7:0]        v;
    logic signed [PROD_W-1:0] prod_r;
    logic signed [PROD_W-1:0] prod_g;
    logic signed [PROD_W-1:0] prod_b;

    // subtracting 128 from an 8-bit value flips its top bit
    assign u = signed'({~chroma_blue[7], chroma_blue[6:0]});
    assign v = signed'({~chroma_red[7],  chroma_red[6:0]});

    assign prod_r = PROD_W'(v) * COEF_RV;
    assign prod_g = PROD_W'(v) * COEF_GV + PROD_W'(u) * COEF_GU;
    assign prod_b = PROD_W'(u) * COEF_BU;

    // arithmetic shift gives the floor
    assign delta.dr = DELTA_W'(prod_r >>> 8);
    assign delta.dg = DELTA_W'(prod_g >>> 8);
    assign delta.db = DELTA_W'(prod_b >>> 8);

endmodule

// ===== src/y2argb_lane.sv =====
// ---------------------------------------------------------------------------
// y2argb_lane
// One pixel lane: adds the red and blue chroma terms to a luma sample, subtracts the green one, clamps, packs ARGB.
// ---------------------------------------------------------------------------
module y2argb_lane (
    input  logic [7:0]         luma,
    input  y2argb_pkg::delta_t delta,
    output logic [31:0]        pixel
);
    import y2argb_pkg::*;

    logic signed [SUM_W-1:0] y_ext;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;

    function automatic logic [7:0] clamp_chan(input logic signed [SUM_W-1:0] x);
        logic [7:0] res;
        priority if (x < 0) begin
            res = 8'h00;
        end else if (x > SUM_W'(CHAN_MAX)) begin
            res = CHAN_MAX;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    assign y_ext = signed'({2'b00, luma});
    assign sum_r = y_ext + SUM_W'(delta.dr);
    assign sum_g = y_ext - SUM_W'(delta.dg);
    assign sum_b = y_ext + SUM_W'(delta.db);

    assign pixel = {ALPHA_OPAQUE, clamp_chan(sum_r), clamp_chan(sum_g), clamp_chan(sum_b)};

endmodule

// ===== src/yuv422_pair_to_argb.sv =====
// ---------------------------------------------------------------------------
// yuv422_pair_to_argb
// BT.601 integer conversion of one 4:2:2 pixel pair into two ARGB words.
// ---------------------------------------------------------------------------
// One pixel pair (two luma samples and their shared Cb/Cr) enters per clock
// and leaves as two opaque ARGB words. The first stage registers the shared
// chroma terms, then two pixel lanes clamp and pack in parallel into the
// output register. Throughput is one word per clock; a stall on the result
// channel holds both stages and drops s_ready only when both are full.
module yuv422_pair_to_argb (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_luma_even,
    input  logic [7:0]  s_luma_odd,
    input  logic [7:0]  s_chroma_blue,
    input  logic [7:0]  s_chroma_red,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_even,
    output logic [31:0] m_pixel_odd
);
    import y2argb_pkg::*;

    delta_t      delta_in;
    delta_t      delta_reg;
    logic [7:0]  luma_even_reg;
    logic [7:0]  luma_odd_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] pix_even;
    logic [31:0] pix_odd;
    logic [31:0] pix_even_reg;
    logic [31:0] pix_odd_reg;
    logic        en_out;
    logic        en_s1;

    y2argb_chroma u_chroma (
        .chroma_blue (s_chroma_blue),
        .chroma_red  (s_chroma_red),
        .delta       (delta_in)
    );

    y2argb_lane u_lane_even (
        .luma  (luma_even_reg),
        .delta (delta_reg),
        .pixel (pix_even)
    );

    y2argb_lane u_lane_odd (
        .luma  (luma_odd_reg),
        .delta (delta_reg),
        .pixel (pix_odd)
    );

    assign en_out  = !out_valid_reg || m_ready;
    assign en_s1   = !s1_valid_reg || en_out;
    assign s_ready = en_s1;

    assign s1_valid_next  = en_s1  ? s_valid      : s1_valid_reg;
    assign out_valid_next = en_out ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_s1) begin
            delta_reg     <= delta_in;
            luma_even_reg <= s_luma_even;
            luma_odd_reg  <= s_luma_odd;
        end
        if (en_out) begin
            pix_even_reg <= pix_even;
            pix_odd_reg  <= pix_odd;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pixel_even = pix_even_reg;
    assign m_pixel_odd  = pix_odd_reg;

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted word did not reach first stage");

    a_s1_moves_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (!out_valid_reg || m_ready)) |=> m_valid)
        else $error("first stage word not moved to output");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline full and stalled");

    a_alpha_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_even[31:24] == ALPHA_OPAQUE
                     && m_pixel_odd[31:24] == ALPHA_OPAQUE))
        else $error("alpha not opaque");

endmodule

// ===== sim/tb_yuv422_pair_to_argb.sv =====
// ---------------------------------------------------------------------------
// tb_yuv422_pair_to_argb
// Self-checking testbench of the 4:2:2 pixel pair to ARGB converter.
// ---------------------------------------------------------------------------
// Pixel pairs are driven on the s_ channel, and each accepted word is
// converted by an independent integer model into the two expected ARGB
// words. Words leaving on the m_ channel are checked in order against that
// queue. A directed set covers the extremes, centered chroma, floor rounding
// of negative products and channel clamping. Random pairs follow in four
// flow-control phases: free flow, sender gaps, receiver stalls, and both.
// ---------------------------------------------------------------------------
class argb_scoreboard;

    localparam int K_RV = 351;
    localparam int K_GV = 179;
    localparam int K_GU = 86;
    localparam int K_BU = 443;

    logic [63:0] pending_pixels[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function logic [7:0] saturate(int x);
        if (x < 0) begin
            return 8'd0;
        end
        if (x > 255) begin
            return 8'd255;
        end
        return x[7:0];
    endfunction

    function logic [31:0] to_argb(logic [7:0] y, int dr, int dg, int db);
        int yi;
        yi = int'(y);
        return {y2argb_pkg::ALPHA_OPAQUE, saturate(yi + dr), saturate(yi - dg),
                saturate(yi + db)};
    endfunction

    function void note_pair(logic [7:0] ye, logic [7:0] yo, logic [7:0] cb,
                            logic [7:0] cr);
        int u;
        int v;
        int dr;
        int dg;
        int db;
        u  = int'(cb) - 128;
        v  = int'(cr) - 128;
        dr = (K_RV * v) >>> 8;
        dg = (K_GV * v + K_GU * u) >>> 8;
        db = (K_BU * u) >>> 8;
        pending_pixels.push_back({to_argb(ye, dr, dg, db), to_argb(yo, dr, dg, db)});
    endfunction

    function void check_pair(logic [31:0] pe, logic [31:0] po);
        logic [63:0] want;
        if (pending_pixels.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected word: even %h odd %h", pe, po);
            end
            return;
        end
        want = pending_pixels.pop_front();
        if (pe !== want[63:32] || po !== want[31:0]) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: even exp %h got %h, odd exp %h got %h",
                         want[63:32], pe, want[31:0], po);
            end
        end
    endfunction

endclass

module tb_yuv422_pair_to_argb;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_luma_even;
    logic [7:0]  s_luma_odd;
    logic [7:0]  s_chroma_blue;
    logic [7:0]  s_chroma_red;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_pixel_even;
    logic [31:0] m_pixel_odd;

    argb_scoreboard board;
    int             send_idle;
    int             recv_stall;

    yuv422_pair_to_argb dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma_even   (s_luma_even),
        .s_luma_odd    (s_luma_odd),
        .s_chroma_blue (s_chroma_blue),
        .s_chroma_red  (s_chroma_red),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_even  (m_pixel_even),
        .m_pixel_odd   (m_pixel_odd)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.note_pair(s_luma_even, s_luma_odd, s_chroma_blue, s_chroma_red);
            end
            if (m_valid && m_ready) begin
                board.check_pair(m_pixel_even, m_pixel_odd);
            end
        end
    end

    // edge-heavy sample picker
    function automatic logic [7:0] pick_sample();
        logic [7:0] edges[7];
        edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(99) < 25) begin
            return edges[$urandom_range(6)];
        end
        return 8'($urandom);
    endfunction

    task automatic send_pair(input logic [7:0] ye, input logic [7:0] yo,
                             input logic [7:0] cb, input logic [7:0] cr);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_luma_even   <= ye;
        s_luma_odd    <= yo;
        s_chroma_blue <= cb;
        s_chroma_red  <= cr;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    initial begin
        board         = new();
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_luma_even   = 8'd0;
        s_luma_odd    = 8'd0;
        s_chroma_blue = 8'd0;
        s_chroma_red  = 8'd0;
        m_ready       = 1'b0;
        send_idle     = 0;
        recv_stall    = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // extremes, centered chroma, floor of negative products, clamping
        send_pair(8'd0,   8'd0,   8'd0,   8'd0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd255);
        send_pair(8'd0,   8'd255, 8'd128, 8'd128);
        send_pair(8'd128, 8'd127, 8'd128, 8'd128);
        send_pair(8'd100, 8'd101, 8'd127, 8'd127);
        send_pair(8'd100, 8'd101, 8'd129, 8'd129);
        send_pair(8'd50,  8'd200, 8'd127, 8'd129);
        send_pair(8'd50,  8'd200, 8'd129, 8'd127);
        send_pair(8'd255, 8'd0,   8'd255, 8'd0);
        send_pair(8'd255, 8'd0,   8'd0,   8'd255);
        send_pair(8'd250, 8'd5,   8'd200, 8'd200);
        send_pair(8'd5,   8'd250, 8'd40,  8'd40);
        send_pair(8'd1,   8'd254, 8'd1,   8'd254);
        send_pair(8'd170, 8'd85,  8'd85,  8'd170);
        send_pair(8'd85,  8'd170, 8'd170, 8'd85);
        send_pair(8'd16,  8'd235, 8'd16,  8'd240);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 47;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 47;
                end
                default: begin
                    send_idle  = 17;
                    recv_stall = 17;
                end
            endcase
            repeat (322) begin
                send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending_pixels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== yuv422_pair_to_argb.f =====
src/y2argb_pkg.sv
src/y2argb_chroma.sv
src/y2argb_lane.sv
src/yuv422_pair_to_argb.sv
sim/tb_yuv422_pair_to_argb.sv
